// ===== hdl/somt_pkg.sv =====
package somt_pkg;

  localparam int TABLE_SLOTS    = 16;
  localparam int COORD_BITS     = 12;
  localparam int COUNT_BITS     = $clog2(TABLE_SLOTS + 1);
  localparam int ID_BITS        = 16;
  localparam int FRAME_BITS     = 16;
  localparam int EPS_BITS       = 11;
  localparam int CMD_BITS       = 3;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  // Width wide enough for both a centre offset and twice the nearness.
  localparam int DIFF_BITS      = (COORD_BITS > EPS_BITS + 1) ? COORD_BITS : EPS_BITS + 1;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] SLOTS_COUNT = COUNT_BITS'(TABLE_SLOTS);

  localparam logic [CMD_BITS-1:0] CMD_CHECK    = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_DELETE   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR_ID = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_BUMP     = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_AGE      = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_RESET    = 3'd5;

  localparam logic [STATUS_BITS-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SUSPECT_FRAMES = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPIRE_FRAMES  = 4'd1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_EVAL,
    CELL_SHIFT,
    CELL_APPEND
  } cell_mode_t;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] bottom;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] left;
  } box_t;

  typedef struct packed {
    logic                  valid;
    logic                  kill;
    logic [ID_BITS-1:0]    owner;
    logic [FRAME_BITS-1:0] life;
    box_t                  box;
    logic [FRAME_BITS-1:0] misses;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '0;

  typedef struct packed {
    cell_mode_t            mode;
    logic [CMD_BITS-1:0]   cmd;
    logic [ID_BITS-1:0]    id;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [EPS_BITS:0]     eps2;
    logic [FRAME_BITS-1:0] expire;
    logic                  merge;
    logic [ID_BITS-1:0]    new_owner;
    logic [FRAME_BITS-1:0] new_life;
    box_t                  new_box;
  } cell_ctrl_t;

endpackage

// ===== hdl/suspect_object_merge_table_top.sv =====
// Channel | Direction | Handshake              | Beat contents
// in      | input     | in_valid / in_stall    | command, object_id, still_frames, box, centre, nearness
// out     | output    | out_valid / out_stall  | frames_out, status, entries_used
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (0 suspect, 1 expire)
//
// An item is evaluated when it is taken, then needs one shift for every entry it removes
// from the table; the compaction shifts the cell chain down one place per cycle.
// A result waits in the output register while the next item is taken; the finishing
// cycle of that next item waits for the output register to be free.
// Synchronous active-high reset empties the table and clears both registers to zero.
module suspect_object_merge_table_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [somt_pkg::CMD_BITS-1:0]       command,
  input  logic [somt_pkg::ID_BITS-1:0]        object_id,
  input  logic [somt_pkg::FRAME_BITS-1:0]     still_frames,
  input  logic [somt_pkg::COORD_BITS-1:0]     box_left,
  input  logic [somt_pkg::COORD_BITS-1:0]     box_right,
  input  logic [somt_pkg::COORD_BITS-1:0]     box_top,
  input  logic [somt_pkg::COORD_BITS-1:0]     box_bottom,
  input  logic [somt_pkg::COORD_BITS-1:0]     centre_x,
  input  logic [somt_pkg::COORD_BITS-1:0]     centre_y,
  input  logic [somt_pkg::EPS_BITS-1:0]       nearness,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [somt_pkg::FRAME_BITS-1:0]     frames_out,
  output logic [somt_pkg::STATUS_BITS-1:0]    status,
  output logic [somt_pkg::COUNT_BITS-1:0]     entries_used,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [somt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [somt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import somt_pkg::*;

  // Control and configuration state.
  state_t                 state;
  state_t                 state_next;
  logic [FRAME_BITS-1:0]  suspect_frames;
  logic [FRAME_BITS-1:0]  expire_frames;
  logic [COUNT_BITS-1:0]  count;

  // The item being worked on.
  logic [ID_BITS-1:0]     id_q;
  logic [FRAME_BITS-1:0]  frames_q;
  box_t                   box_q;
  logic                   trigger;
  logic [STATUS_BITS-1:0] status_q;
  logic [FRAME_BITS-1:0]  sum;

  // Cell chain wiring.
  cell_ctrl_t             ctrl;
  entry_t                 cell_entry [TABLE_SLOTS];
  entry_t                 cell_upper [TABLE_SLOTS];
  logic                   cell_lower_valid [TABLE_SLOTS];
  logic [TABLE_SLOTS:0]   seen_chain;
  logic [FRAME_BITS-1:0]  life_tap [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_vec;
  logic [TABLE_SLOTS-1:0] kill_vec;

  logic                   accept;
  logic                   out_free;
  logic                   any_kill;
  logic                   done;
  logic                   append;
  logic                   full;
  logic [FRAME_BITS-1:0]  tap_life;
  logic [FRAME_BITS:0]    sum_wide;
  logic [FRAME_BITS-1:0]  sum_sat;

  assign seen_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    // Data moves down the chain on a shift; the top cell is fed an empty slot.
    if (i == TABLE_SLOTS - 1) begin : g_top
      assign cell_upper[i] = ENTRY_EMPTY;
    end else begin : g_mid
      assign cell_upper[i] = cell_entry[i+1];
    end
    // An append lands in the lowest empty cell, which is the one above the last valid cell.
    if (i == 0) begin : g_first
      assign cell_lower_valid[i] = 1'b1;
    end else begin : g_rest
      assign cell_lower_valid[i] = cell_entry[i-1].valid;
    end

    somt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .upper       (cell_upper[i]),
      .lower_valid (cell_lower_valid[i]),
      .seen_in     (seen_chain[i]),
      .seen_out    (seen_chain[i+1]),
      .entry       (cell_entry[i]),
      .life_tap    (life_tap[i])
    );

    assign valid_vec[i] = cell_entry[i].valid;
    assign kill_vec[i] = cell_entry[i].kill;
  end

  // Only the lowest marked cell drives its lifetime, so an OR collects it.
  always_comb begin
    tap_life = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tap_life = tap_life | life_tap[i];
    end
    sum_wide = {1'b0, sum} + {1'b0, tap_life};
    sum_sat = sum_wide[FRAME_BITS] ? FRAME_MAX : sum_wide[FRAME_BITS-1:0];
  end

  assign any_kill = |kill_vec;
  assign full = (count == SLOTS_COUNT);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // On acceptance the idle state evaluates every cell against the incoming beat directly.
  // The work state then shifts out one marked entry per cycle and, once none is left and the
  // output is free, appends the new entry for a triggered check with room and posts the result.
  always_comb begin
    state_next = state;
    done = 1'b0;
    append = 1'b0;
    ctrl.mode = CELL_HOLD;
    ctrl.cmd = command;
    ctrl.id = object_id;
    ctrl.cx = centre_x;
    ctrl.cy = centre_y;
    ctrl.eps2 = {nearness, 1'b0};
    ctrl.expire = expire_frames;
    ctrl.merge = (command == CMD_CHECK) && (still_frames == suspect_frames);
    ctrl.new_owner = id_q;
    ctrl.new_life = sum;
    ctrl.new_box = box_q;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctrl.mode = CELL_EVAL;
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        if (any_kill) begin
          ctrl.mode = CELL_SHIFT;
        end else if (out_free) begin
          done = 1'b1;
          append = trigger && !full;
          if (append) begin
            ctrl.mode = CELL_APPEND;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      suspect_frames <= '0;
      expire_frames <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SUSPECT_FRAMES: suspect_frames <= cfg_data;
        REG_EXPIRE_FRAMES:  expire_frames <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Item registers and the merged lifetime sum.
  always_ff @(posedge clk) begin
    if (accept) begin
      id_q <= object_id;
      frames_q <= still_frames;
      box_q <= '{bottom: box_bottom, top: box_top, right: box_right, left: box_left};
      trigger <= ctrl.merge;
      sum <= still_frames;
      if ((command inside {CMD_DELETE, CMD_CLEAR_ID, CMD_BUMP}) && !seen_chain[TABLE_SLOTS]) begin
        status_q <= STATUS_NOT_FOUND;
      end else begin
        status_q <= STATUS_DONE;
      end
    end else if (state == S_WORK && any_kill && trigger) begin
      sum <= sum_sat;
    end
  end

  // Entry count follows the cell chain: cleared by the reset command, one less per
  // shift, one more per append.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && command == CMD_RESET) begin
      count <= '0;
    end else if (state == S_WORK && any_kill) begin
      count <= count - 1'b1;
    end else if (append) begin
      count <= count + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      frames_out <= trigger ? sum : frames_q;
      status <= (trigger && full) ? STATUS_FULL : status_q;
      entries_used <= count + {{(COUNT_BITS-1){1'b0}}, append};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= SLOTS_COUNT)
    else $error("entry count above table size");
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count does not match valid cells");
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells do not form a prefix");
  a_kill_on_valid: assert property (@(posedge clk) disable iff (rst) (kill_vec & ~valid_vec) == '0)
    else $error("removal mark on an empty cell");
  a_shift_drops_one: assert property (@(posedge clk) disable iff (rst)
    state == S_WORK && any_kill |=> count == $past(count) - 1'b1)
    else $error("shift did not remove exactly one entry");
`endif

endmodule

// ===== hdl/somt_cell.sv =====
module somt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  somt_pkg::cell_ctrl_t          ctrl,
  input  somt_pkg::entry_t              upper,
  input  logic                          lower_valid,
  input  logic                          seen_in,
  output logic                          seen_out,
  output somt_pkg::entry_t              entry,
  output logic [somt_pkg::FRAME_BITS-1:0] life_tap
);
  import somt_pkg::*;

  entry_t                entry_next;
  logic [COORD_BITS:0]   sum_x;
  logic [COORD_BITS:0]   sum_y;
  logic [COORD_BITS-1:0] ex;
  logic [COORD_BITS-1:0] ey;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  near;
  logic                  id_match;
  logic                  term;
  logic                  first;
  logic [FRAME_BITS-1:0] miss_inc;

  always_comb begin
    sum_x = {1'b0, entry.box.left} + {1'b0, entry.box.right};
    sum_y = {1'b0, entry.box.top} + {1'b0, entry.box.bottom};
    ex = sum_x[COORD_BITS:1];
    ey = sum_y[COORD_BITS:1];
    dx = (ex >= ctrl.cx) ? ex - ctrl.cx : ctrl.cx - ex;
    dy = (ey >= ctrl.cy) ? ey - ctrl.cy : ctrl.cy - ey;
    near = (DIFF_BITS'(dx) < DIFF_BITS'(ctrl.eps2)) && (DIFF_BITS'(dy) < DIFF_BITS'(ctrl.eps2));
    id_match = entry.valid && (entry.owner == ctrl.id);
    miss_inc = (entry.misses == FRAME_MAX) ? entry.misses : entry.misses + 1'b1;

    // During a shift the chain marks the lowest pending removal; otherwise the first id match.
    term = (ctrl.mode == CELL_SHIFT) ? entry.kill : id_match;
    first = term && !seen_in;
    seen_out = seen_in || term;
    life_tap = (ctrl.mode == CELL_SHIFT && first) ? entry.life : '0;

    entry_next = entry;
    case (ctrl.mode)
      CELL_EVAL: begin
        entry_next.kill = 1'b0;
        case (ctrl.cmd)
          CMD_CHECK: begin
            if (ctrl.merge) begin
              entry_next.kill = entry.valid && near;
            end
          end
          CMD_DELETE: begin
            entry_next.kill = first;
          end
          CMD_CLEAR_ID: begin
            if (first) begin
              entry_next.owner = '0;
            end
          end
          CMD_BUMP: begin
            if (first && entry.life != FRAME_MAX) begin
              entry_next.life = entry.life + 1'b1;
            end
          end
          CMD_AGE: begin
            if (entry.valid && entry.owner == '0) begin
              entry_next.misses = miss_inc;
              entry_next.kill = miss_inc > ctrl.expire;
            end
          end
          CMD_RESET: begin
            entry_next.valid = 1'b0;
          end
          default: begin
          end
        endcase
      end
      CELL_SHIFT: begin
        if (seen_out) begin
          entry_next = upper;
        end
      end
      CELL_APPEND: begin
        if (lower_valid && !entry.valid) begin
          entry_next.valid = 1'b1;
          entry_next.kill = 1'b0;
          entry_next.owner = ctrl.new_owner;
          entry_next.life = ctrl.new_life;
          entry_next.box = ctrl.new_box;
          entry_next.misses = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      entry.kill <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

// ===== dv/suspect_object_merge_table_top_test.sv =====
module suspect_object_merge_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import somt_pkg::*;

  // The two command codes the block decodes as no-ops.
  localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

  // Register indexes with no register behind them; the top one and the one that
  // shares its low bit with the suspect register catch a sloppy address decode.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED  = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALIAS_SUSPECT = 4'd14;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_INDEX     = '1;

  localparam int SAT_LIMIT   = 2 ** FRAME_BITS - 1;
  localparam int COORD_MAX   = 2 ** COORD_BITS - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_LIMIT = 40;

  // One command beat as it goes into the block.
  typedef struct packed {
    logic [CMD_BITS-1:0]   cmd;
    logic [ID_BITS-1:0]    id;
    logic [FRAME_BITS-1:0] frames;
    box_t                  box;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [EPS_BITS-1:0]   eps;
  } table_cmd_t;

  // One reply beat as it comes out of the block.
  typedef struct packed {
    logic [FRAME_BITS-1:0]  frames;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  used;
  } table_reply_t;

  // Our own copy of one valid table entry.
  typedef struct {
    logic [ID_BITS-1:0]    owner;
    logic [FRAME_BITS-1:0] life;
    box_t                  box;
    logic [FRAME_BITS-1:0] misses;
  } suspect_slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_BITS-1:0]       command = '0;
  logic [ID_BITS-1:0]        object_id = '0;
  logic [FRAME_BITS-1:0]     still_frames = '0;
  logic [COORD_BITS-1:0]     box_left = '0;
  logic [COORD_BITS-1:0]     box_right = '0;
  logic [COORD_BITS-1:0]     box_top = '0;
  logic [COORD_BITS-1:0]     box_bottom = '0;
  logic [COORD_BITS-1:0]     centre_x = '0;
  logic [COORD_BITS-1:0]     centre_y = '0;
  logic [EPS_BITS-1:0]       nearness = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [FRAME_BITS-1:0]     frames_out;
  logic [STATUS_BITS-1:0]    status;
  logic [COUNT_BITS-1:0]     entries_used;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Shadow state: the ordered list of valid entries (oldest first) and both registers.
  suspect_slot_t         suspects[$];
  logic [FRAME_BITS-1:0] suspect_thr = '0;
  logic [FRAME_BITS-1:0] expire_thr = '0;

  // Replies we have predicted but not yet seen, in command order.
  table_reply_t pending_replies[$];
  table_reply_t oldest_reply;

  int  errors = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  // When set, neither side inserts bubbles, so beats run back to back.
  bit  calm = 1'b0;

  suspect_object_merge_table_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .object_id    (object_id),
    .still_frames (still_frames),
    .box_left     (box_left),
    .box_right    (box_right),
    .box_top      (box_top),
    .box_bottom   (box_bottom),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .nearness     (nearness),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frames_out   (frames_out),
    .status       (status),
    .entries_used (entries_used),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a reply.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("suspect_object_merge_table_top_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int abs_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return COORD_BITS'(v);
  endfunction

  // Position of the first entry owned by id, or -1. A cleared owner reads as id zero.
  function automatic int find_owner(input logic [ID_BITS-1:0] id);
    foreach (suspects[i])
      if (suspects[i].owner == id) return i;
    return -1;
  endfunction

  // Applies one command to the shadow table and returns the reply it must produce.
  function automatic table_reply_t apply_command(input table_cmd_t c);
    table_reply_t  r;
    suspect_slot_t fresh;
    int            sum;
    int            eps2;
    int            ex;
    int            ey;
    int            i;
    int            hit;
    r.frames = c.frames;
    r.status = STATUS_DONE;
    case (c.cmd)
      CMD_CHECK: begin
        // Only a check that lands exactly on the suspect threshold touches the table.
        if (c.frames == suspect_thr) begin
          sum  = c.frames;
          eps2 = 2 * int'(c.eps);
          i    = 0;
          while (i < suspects.size()) begin
            ex = (int'(suspects[i].box.left) + int'(suspects[i].box.right)) / 2;
            ey = (int'(suspects[i].box.top) + int'(suspects[i].box.bottom)) / 2;
            if (abs_gap(ex, int'(c.cx)) < eps2 && abs_gap(ey, int'(c.cy)) < eps2) begin
              sum += suspects[i].life;
              if (sum > SAT_LIMIT) sum = SAT_LIMIT;
              suspects.delete(i);
            end else begin
              i++;
            end
          end
          // The merge removal happens even when the table then has no room.
          if (suspects.size() < TABLE_SLOTS) begin
            fresh.owner  = c.id;
            fresh.life   = FRAME_BITS'(sum);
            fresh.box    = c.box;
            fresh.misses = '0;
            suspects.insert(suspects.size(), fresh);
          end else begin
            r.status = STATUS_FULL;
          end
          r.frames = FRAME_BITS'(sum);
        end
      end
      CMD_DELETE: begin
        hit = find_owner(c.id);
        if (hit < 0) r.status = STATUS_NOT_FOUND;
        else suspects.delete(hit);
      end
      CMD_CLEAR_ID: begin
        hit = find_owner(c.id);
        if (hit < 0) r.status = STATUS_NOT_FOUND;
        else suspects[hit].owner = '0;
      end
      CMD_BUMP: begin
        hit = find_owner(c.id);
        if (hit < 0) r.status = STATUS_NOT_FOUND;
        else if (suspects[hit].life != FRAME_MAX) suspects[hit].life = suspects[hit].life + 1'b1;
      end
      CMD_AGE: begin
        // Orphaned entries count a miss and go once they have missed too often.
        i = 0;
        while (i < suspects.size()) begin
          if (suspects[i].owner == '0) begin
            if (suspects[i].misses != FRAME_MAX) suspects[i].misses = suspects[i].misses + 1'b1;
            if (suspects[i].misses > expire_thr) begin
              suspects.delete(i);
              continue;
            end
          end
          i++;
        end
      end
      CMD_RESET: suspects.delete();
      default: ;
    endcase
    r.used = COUNT_BITS'(suspects.size());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("MISMATCH beat %0d %s: got %0d, want %0d", results_seen, what, got, want);
  endtask

  // Every accepted reply beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no command pending", int'(frames_out), -1);
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (frames_out !== oldest_reply.frames)
          report_mismatch("frames_out", int'(frames_out), int'(oldest_reply.frames));
        if (status !== oldest_reply.status)
          report_mismatch("status", int'(status), int'(oldest_reply.status));
        if (entries_used !== oldest_reply.used)
          report_mismatch("entries_used", int'(entries_used), int'(oldest_reply.used));
      end
    end
  end

  // Reply side: before each beat the receiver holds stall high for a random number
  // of cycles, whether or not a reply is waiting, so back-pressure lands on every
  // phase of the block's work. Apart from the first, a raise only ever follows an accepted beat.
  initial begin
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one command beat after a random bubble. Valid stays high when the next
  // beat follows with no bubble; the prediction is made at the accepting edge.
  task automatic send_item(input table_cmd_t c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command      <= c.cmd;
    object_id    <= c.id;
    still_frames <= c.frames;
    box_left     <= c.box.left;
    box_right    <= c.box.right;
    box_top      <= c.box.top;
    box_bottom   <= c.box.bottom;
    centre_x     <= c.cx;
    centre_y     <= c.cy;
    nearness     <= c.eps;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_replies.insert(pending_replies.size(), apply_command(c));
  endtask

  // Every command produces a reply, so once nothing is pending the block is idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Valid drops for one cycle after each write, so back-to-back writes never
  // schedule two updates of it in one step.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] value);
    cfg_index <= index;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == REG_SUSPECT_FRAMES) suspect_thr = value;
    else if (index == REG_EXPIRE_FRAMES) expire_thr = value;
    @(posedge clk);
  endtask

  function automatic table_cmd_t make_cmd(
    input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] id,
    input logic [FRAME_BITS-1:0] frames,
    input logic [COORD_BITS-1:0] l, input logic [COORD_BITS-1:0] r,
    input logic [COORD_BITS-1:0] t, input logic [COORD_BITS-1:0] b,
    input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
    input logic [EPS_BITS-1:0] eps);
    table_cmd_t c;
    c.cmd        = cmd;
    c.id         = id;
    c.frames     = frames;
    c.box.left   = l;
    c.box.right  = r;
    c.box.top    = t;
    c.box.bottom = b;
    c.cx         = cx;
    c.cy         = cy;
    c.eps        = eps;
    return c;
  endfunction

  // Builds a mostly well-formed command: ids are usually ones that sit in the table,
  // checks usually hit the threshold and aim near an existing entry so merges happen.
  // A share of fully random fields keeps every input bit moving.
  function automatic table_cmd_t random_command();
    table_cmd_t c;
    int         roll;
    int         pick;
    roll = $urandom_range(0, 99);
    if (roll < 40) c.cmd = CMD_CHECK;
    else if (roll < 52) c.cmd = CMD_DELETE;
    else if (roll < 64) c.cmd = CMD_CLEAR_ID;
    else if (roll < 78) c.cmd = CMD_BUMP;
    else if (roll < 97) c.cmd = CMD_AGE;
    else if (roll < 98) c.cmd = CMD_RESET;
    else c.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;

    roll = $urandom_range(0, 9);
    if (suspects.size() != 0 && roll < 6)
      c.id = suspects[$urandom_range(0, suspects.size() - 1)].owner;
    else if (roll < 8) c.id = ID_BITS'($urandom_range(0, 7));
    else c.id = ID_BITS'($urandom);

    roll = $urandom_range(0, 9);
    if (roll < 7) c.frames = suspect_thr;
    else if (roll == 7) c.frames = suspect_thr + 1'b1;
    else c.frames = FRAME_BITS'($urandom);

    c.box.left = COORD_BITS'($urandom);
    c.box.top  = COORD_BITS'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      c.box.right  = clamp_coord(int'(c.box.left) + $urandom_range(0, 300));
      c.box.bottom = clamp_coord(int'(c.box.top) + $urandom_range(0, 300));
    end else begin
      c.box.right  = COORD_BITS'($urandom);
      c.box.bottom = COORD_BITS'($urandom);
    end

    if (suspects.size() != 0 && $urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, suspects.size() - 1);
      c.cx = clamp_coord((int'(suspects[pick].box.left) + int'(suspects[pick].box.right)) / 2
                         + $urandom_range(0, 80) - 40);
      c.cy = clamp_coord((int'(suspects[pick].box.top) + int'(suspects[pick].box.bottom)) / 2
                         + $urandom_range(0, 80) - 40);
    end else begin
      c.cx = COORD_BITS'($urandom);
      c.cy = COORD_BITS'($urandom);
    end
    c.eps = ($urandom_range(0, 9) == 0) ? EPS_BITS'($urandom) : EPS_BITS'($urandom_range(0, 40));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Runs straight after reset, so both registers are zero: a still count of zero
  // triggers the merge, and any orphaned entry goes on its first sweep.
  task automatic test_basic_commands();
    // Insert into an empty table, then a check off the threshold that changes nothing.
    send_item(make_cmd(CMD_CHECK, 16'd5, 16'd0, 100, 200, 100, 200, 1000, 1000, 0));
    send_item(make_cmd(CMD_CHECK, 16'd7, 16'd1, 100, 200, 100, 200, 1000, 1000, 0));
    send_item(make_cmd(CMD_BUMP, 16'd5, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    // A centre right on the entry merges it and carries its lifetime into the new one.
    send_item(make_cmd(CMD_CHECK, 16'd9, 16'd0, 4095, 4095, 4095, 4095, 150, 150, 1));
    // An offset equal to twice the nearness is not close enough.
    send_item(make_cmd(CMD_CHECK, 16'd11, 16'd0, 0, 0, 0, 0, 4091, 4095, 2));
    send_item(make_cmd(CMD_DELETE, 16'd123, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    // Clearing the owner makes the entry answer to id zero, then the sweep drops it.
    send_item(make_cmd(CMD_CLEAR_ID, 16'd9, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_BUMP, 16'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_AGE, 16'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_DELETE, 16'd11, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_CHECK, 16'hFFFF, 16'd0, 0, 0, 0, 0, 4095, 4095, 2047));
    send_item(make_cmd(CMD_RESET, 16'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_SPARE_LO, 16'hA5A5, 16'h5A5A, 1, 2, 3, 4, 5, 6, 7));
    send_item(make_cmd(CMD_SPARE_HI, 16'h5A5A, 16'hA5A5, 7, 6, 5, 4, 3, 2, 1));
    wait_idle();
  endtask

  // Fills all slots at the top threshold, has one insert refused, then lets a wide
  // check swallow the whole table so the summed count saturates and the compaction
  // runs its longest.
  task automatic test_full_table_and_saturation();
    write_register(REG_SUSPECT_FRAMES, '1);
    write_register(REG_EXPIRE_FRAMES, '1);
    for (int k = 0; k <= TABLE_SLOTS; k++)
      send_item(make_cmd(CMD_CHECK, ID_BITS'(k + 1), '1, COORD_BITS'(k * 8),
                         COORD_BITS'(k * 8 + 4), COORD_BITS'(k * 8),
                         COORD_BITS'(k * 8 + 6), 4095, 0, 0));
    send_item(make_cmd(CMD_CHECK, 16'd100, '1, 4095, 4095, 4095, 4095, 2047, 2047, 2047));
    // The lifetime is already at its ceiling, so the bump must hold it there.
    send_item(make_cmd(CMD_BUMP, 16'd100, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_CHECK, 16'd101, '1, 0, 0, 0, 0, 4095, 4095, 1));
    send_item(make_cmd(CMD_RESET, 16'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  // Writes to indexes with no register behind them must leave both registers alone.
  task automatic test_unused_register_index();
    write_register(REG_TOP_INDEX, '0);
    write_register(REG_ALIAS_SUSPECT, '0);
    write_register(CFG_INDEX_BITS'($urandom_range(REG_FIRST_UNUSED, REG_ALIAS_SUSPECT - 1)),
                   CFG_DATA_BITS'($urandom));
    // With the suspect threshold still at its top value this check must not insert.
    send_item(make_cmd(CMD_CHECK, 16'd1, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(CMD_CLEAR_ID, 16'd1, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  // One phase of random traffic under a given pair of register values. The pace
  // switches now and then between random bubbles and back-to-back beats.
  task automatic test_random_traffic(input int count, input logic [FRAME_BITS-1:0] thr,
                                     input logic [FRAME_BITS-1:0] expire_lim);
    write_register(REG_SUSPECT_FRAMES, thr);
    write_register(REG_EXPIRE_FRAMES, expire_lim);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      send_item(random_command());
    end
    wait_idle();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_commands();
    test_full_table_and_saturation();
    test_unused_register_index();
    test_random_traffic(364, '0, '0);
    test_random_traffic(364, FRAME_BITS'($urandom), FRAME_BITS'(2));
    test_random_traffic(364, '1, '1);
    test_random_traffic(364, FRAME_BITS'($urandom), FRAME_BITS'($urandom_range(1, 6)));
    test_random_traffic(364, FRAME_BITS'($urandom), FRAME_BITS'($urandom));

    // Leave room for any stray reply that should not exist.
    repeat (TABLE_SLOTS + 8) @(posedge clk);
    if (errors == 0) begin
      $display("suspect_object_merge_table_top_test: clean");
    end else begin
      $display("suspect_object_merge_table_top_test: errors");
    end
    $finish;
  end

endmodule

// ===== suspect_object_merge_table_top.f =====
hdl/somt_pkg.sv
hdl/somt_cell.sv
hdl/suspect_object_merge_table_top.sv
dv/suspect_object_merge_table_top_test.sv
